### hdl/pacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacl_pkg
// Shared types and constants of the per-address connection limiter.
// ----------------------------------------------------------------------------
package pacl_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 16;
  localparam int OP_W    = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_W-1:0] MAX_PER_RST = 16'd16;

  localparam logic [OP_W-1:0] OP_CHECK  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_CHKUPD = 3'd3;
  localparam logic [OP_W-1:0] OP_SETUPD = 3'd4;

  // one table slot as stored in the memory
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic               flag;
  } entry_t;

  // result of one operation
  typedef struct packed {
    logic               answer;
    logic               found;
    logic               full;
    logic [COUNT_W-1:0] count;
  } result_t;

  // write-back decision of one operation
  typedef struct packed {
    logic   wr_en;
    logic   use_free;
    entry_t wr_entry;
  } wback_t;

endpackage

### hdl/per_address_connection_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_address_connection_limiter
// Per-source-address connection table with admission check and update flag.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every slot with busy
// high. An operation is taken when start is high and busy is low; the table
// memory is then scanned one slot per cycle, and busy stays high through the
// scan, a drain state and a finish state that writes the slot back. The result
// is on the out_ ports, marked by out_valid, for one cycle; out_valid is
// registered from the finish state. The receiver cannot stall; the next start
// may be given in the cycle the result is shown. cfg_wr_en writes
// max_per_address and is meant to be used only while busy is low.
// ----------------------------------------------------------------------------
module per_address_connection_limiter
  import pacl_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [KEY_W-1:0]   in_address,
  input  logic               in_update_value,
  output logic               out_valid,
  output logic               out_answer,
  output logic               out_found,
  output logic               out_table_full,
  output logic [COUNT_W-1:0] out_count_after
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  logic [COUNT_W-1:0] max_per_address_r;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  entry_t             mem_rdata;
  result_t            res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_per_address_r <= MAX_PER_RST;
    end else if (cfg_wr_en) begin
      max_per_address_r <= cfg_wr_data;
    end
  end

  pacl_mem #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pacl_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .op              (in_opcode),
    .key             (in_address),
    .update_value    (in_update_value),
    .max_per_address (max_per_address_r),
    .busy            (busy),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata),
    .res_valid       (out_valid),
    .res             (res)
  );

  assign out_answer      = res.answer;
  assign out_found       = res.found;
  assign out_table_full  = res.full;
  assign out_count_after = res.count;

`ifndef SYNTHESIS
  // a dropped insert reports no count
  a_full_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_count_after == '0 && !out_found)
    else $error("table_full with nonzero count or found");

  // an absent address can only end up with the count of a fresh insert
  a_absent_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_count_after <= 16'd1)
    else $error("absent address reports count above one");

  // the scan keeps the block busy after a start transfer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("not busy right after start transfer");

  // results never come in consecutive cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");
`endif

endmodule

### hdl/pacl_op.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacl_op
// Applies one operation to the looked-up slot and decides the write-back.
// ----------------------------------------------------------------------------
module pacl_op
  import pacl_pkg::*;
(
  input  logic [OP_W-1:0]    op,
  input  logic [KEY_W-1:0]   key,
  input  logic               update_value,
  input  logic [COUNT_W-1:0] max_per_address,
  input  logic               found,
  input  entry_t             hit_entry,
  input  logic               free_found,
  output result_t            res,
  output wback_t             wback
);

  logic   locked;
  entry_t new_e;

  assign locked = found && (hit_entry.count > 16'd1) && hit_entry.flag;

  always_comb begin
    new_e          = hit_entry;
    res.answer     = 1'b0;
    res.found      = found;
    res.full       = 1'b0;
    wback.wr_en    = 1'b0;
    wback.use_free = 1'b0;
    case (op)
      OP_CHECK: begin
        res.answer = found ? (hit_entry.count < max_per_address)
                           : (max_per_address != '0);
      end
      OP_INSERT: begin
        if (found) begin
          if (hit_entry.count != COUNT_MAX) begin
            new_e.count = hit_entry.count + 16'd1;
          end
          wback.wr_en = 1'b1;
        end else if (free_found) begin
          new_e.valid    = 1'b1;
          new_e.key      = key;
          new_e.count    = 16'd1;
          new_e.flag     = 1'b0;
          wback.wr_en    = 1'b1;
          wback.use_free = 1'b1;
        end else begin
          res.full = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          new_e.count = hit_entry.count - 16'd1;
          // last connection gone frees the slot
          if (new_e.count == '0) begin
            new_e.valid = 1'b0;
          end
          wback.wr_en = 1'b1;
        end
      end
      OP_CHKUPD: begin
        res.answer = locked;
      end
      OP_SETUPD: begin
        if (!locked) begin
          res.answer = 1'b1;
          if (found) begin
            new_e.flag  = update_value;
            wback.wr_en = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (found && new_e.valid) begin
      res.count = new_e.count;
    end else if (wback.use_free) begin
      res.count = 16'd1;
    end else begin
      res.count = '0;
    end
    wback.wr_entry = new_e;
  end

endmodule

### hdl/pacl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacl_mem
// Slot table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pacl_mem
  import pacl_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/pacl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacl_ctrl
// Sequencer: clears the table after reset, scans it for each operation,
// then writes the modified slot back and issues the result.
// ----------------------------------------------------------------------------
module pacl_ctrl
  import pacl_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [OP_W-1:0]    op,
  input  logic [KEY_W-1:0]   key,
  input  logic               update_value,
  input  logic [COUNT_W-1:0] max_per_address,
  output logic               busy,
  output logic               mem_we,
  output logic [IW-1:0]      mem_waddr,
  output entry_t             mem_wdata,
  output logic               mem_re,
  output logic [IW-1:0]      mem_raddr,
  input  entry_t             mem_rdata,
  output logic               res_valid,
  output result_t            res
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  logic [2:0]         state_r, state_nxt;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      rd_idx_r;
  logic               rd_vld_r;
  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic               upd_r;
  logic               hit_r;
  logic [IW-1:0]      hit_idx_r;
  entry_t             hit_entry_r;
  logic               free_r;
  logic [IW-1:0]      free_idx_r;
  logic               res_valid_r;
  result_t            res_r;
  logic               accept;
  result_t            op_res;
  wback_t             op_wb;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  pacl_op u_op (
    .op              (op_r),
    .key             (key_r),
    .update_value    (upd_r),
    .max_per_address (max_per_address),
    .found           (hit_r),
    .hit_entry       (hit_entry_r),
    .free_found      (free_r),
    .res             (op_res),
    .wback           (op_wb)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (idx_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_SCAN;
      ST_SCAN:   if (idx_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_re    = (state_r == ST_SCAN);
    mem_raddr = idx_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == ST_FINISH) begin
      mem_we    = op_wb.wr_en;
      mem_waddr = op_wb.use_free ? free_idx_r : hit_idx_r;
      mem_wdata = op_wb.wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      res_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= (state_r == ST_SCAN);
      res_valid_r <= (state_r == ST_FINISH);
      if (state_r == ST_CLEAR || state_r == ST_SCAN) begin
        idx_r <= (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      if (accept) begin
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (rd_vld_r) begin
        // lowest matching slot and lowest free slot win
        if (!hit_r && mem_rdata.valid && mem_rdata.key == key_r) begin
          hit_r <= 1'b1;
        end
        if (!free_r && !mem_rdata.valid) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    if (accept) begin
      op_r  <= op;
      key_r <= key;
      upd_r <= update_value;
    end
    if (rd_vld_r && !hit_r && mem_rdata.valid && mem_rdata.key == key_r) begin
      hit_idx_r   <= rd_idx_r;
      hit_entry_r <= mem_rdata;
    end
    if (rd_vld_r && !free_r && !mem_rdata.valid) begin
      free_idx_r <= rd_idx_r;
    end
    if (state_r == ST_FINISH) begin
      res_r <= op_res;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

### test/per_address_connection_limiter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_address_connection_limiter_tb
// Self-checking bench for the per-address connection limiter.
// Connection events are queued up front: directed corner cases first, then
// random phases. Each phase writes a new limit and runs either a mix of
// operations over a few addresses or a sweep that overfills the table and
// drains it. A shadow copy of the table predicts every result at the start
// transfer, and the monitor compares each strobed result with the oldest
// prediction.
// ----------------------------------------------------------------------------
module per_address_connection_limiter_tb;
  import pacl_pkg::*;

  localparam int SLOTS       = DEF_TABLE_ENTRIES;
  localparam int POOL_SIZE   = SLOTS + 8;
  localparam int ITEM_GOAL   = 1300;
  localparam int CALM_TAIL   = 150;
  localparam int DRAIN_CYC   = SLOTS + 16;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  // opcodes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  typedef struct {
    bit                 is_limit;
    logic [COUNT_W-1:0] limit;
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   addr;
    logic               upd;
    int                 gap;
  } conn_event_t;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               cfg_wr_en       = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data     = '0;
  logic               start           = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    in_opcode       = '0;
  logic [KEY_W-1:0]   in_address      = '0;
  logic               in_update_value = 1'b0;
  logic               out_valid;
  logic               out_answer;
  logic               out_found;
  logic               out_table_full;
  logic [COUNT_W-1:0] out_count_after;

  per_address_connection_limiter #(
    .TABLE_ENTRIES(SLOTS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_address     (in_address),
    .in_update_value(in_update_value),
    .out_valid      (out_valid),
    .out_answer     (out_answer),
    .out_found      (out_found),
    .out_table_full (out_table_full),
    .out_count_after(out_count_after)
  );

  conn_event_t conn_events[$];
  result_t     pending_outcomes[$];

  // shadow of the connection table
  logic               shadow_valid [SLOTS];
  logic [KEY_W-1:0]   shadow_key   [SLOTS];
  logic [COUNT_W-1:0] shadow_count [SLOTS];
  logic               shadow_flag  [SLOTS];
  logic [COUNT_W-1:0] shadow_limit = MAX_PER_RST;

  logic [KEY_W-1:0] src_pool [POOL_SIZE];

  int in_flight    = 0;
  int gap_left     = -1;
  int mismatches   = 0;
  int stall_cycles = 0;
  int gap_pct      = 30;
  int n_items      = 0;
  bit calm         = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic result_t predict_table_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                               logic upd);
    result_t r;
    int      hit;
    int      vacant;
    logic    locked;
    r      = '0;
    hit    = -1;
    vacant = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_key[i] == key) hit = i;
      if (vacant < 0 && !shadow_valid[i]) vacant = i;
    end
    r.found = (hit >= 0);
    locked  = (hit >= 0) && shadow_count[hit] > 1 && shadow_flag[hit];
    case (op)
      OP_CHECK: begin
        r.answer = (hit >= 0) ? (shadow_count[hit] < shadow_limit) : (shadow_limit != 0);
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          if (shadow_count[hit] != COUNT_MAX) shadow_count[hit]++;
        end else if (vacant < 0) begin
          r.full = 1'b1;
        end else begin
          shadow_valid[vacant] = 1'b1;
          shadow_key[vacant]   = key;
          shadow_count[vacant] = 16'd1;
          shadow_flag[vacant]  = 1'b0;
          r.count              = 16'd1;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          shadow_count[hit]--;
          if (shadow_count[hit] == 0) shadow_valid[hit] = 1'b0;
        end
      end
      OP_CHKUPD: begin
        r.answer = locked;
      end
      OP_SETUPD: begin
        if (!locked) begin
          r.answer = 1'b1;
          if (hit >= 0) shadow_flag[hit] = upd;
        end
      end
      default: ;
    endcase
    if (hit >= 0 && shadow_valid[hit]) r.count = shadow_count[hit];
    return r;
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void queue_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] addr, logic upd);
    conn_event_t ev;
    ev          = '{default: 0};
    ev.op       = op;
    ev.addr     = addr;
    ev.upd      = upd;
    if (!calm && $urandom_range(99) < gap_pct) ev.gap = $urandom_range(1, 9);
    conn_events.push_back(ev);
    n_items++;
    if (n_items > ITEM_GOAL - CALM_TAIL) calm = 1'b1;
  endfunction

  function automatic void queue_limit(logic [COUNT_W-1:0] limit);
    conn_event_t ev;
    ev          = '{default: 0};
    ev.is_limit = 1'b1;
    ev.limit    = limit;
    conn_events.push_back(ev);
  endfunction

  function automatic logic [OP_W-1:0] random_op();
    int w;
    w = $urandom_range(99);
    if (w < 30) return OP_INSERT;
    if (w < 55) return OP_REMOVE;
    if (w < 70) return OP_CHECK;
    if (w < 80) return OP_CHKUPD;
    if (w < 95) return OP_SETUPD;
    if (w < 97) return OP_SPARE5;
    if (w < 98) return OP_SPARE6;
    return OP_SPARE7;
  endfunction

  // mostly known addresses, now and then a stranger
  function automatic void queue_mix(int pool_n, int n);
    logic [KEY_W-1:0] addr;
    for (int i = 0; i < n; i++) begin
      addr = ($urandom_range(9) == 0) ? $urandom() : src_pool[$urandom_range(pool_n - 1)];
      queue_op(random_op(), addr, 1'($urandom_range(1)));
    end
  endfunction

  // more addresses than slots, so the tail of the sweep is dropped
  function automatic void queue_fill_sweep();
    for (int i = 0; i < POOL_SIZE; i++) queue_op(OP_INSERT, src_pool[i], 1'($urandom_range(1)));
    queue_mix(POOL_SIZE, 20);
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        queue_op(OP_REMOVE, src_pool[i], 1'($urandom_range(1)));
      end
    end
  endfunction

  initial begin : stimulus
    logic [KEY_W-1:0]   lo_addr;
    logic [KEY_W-1:0]   hi_addr;
    logic [COUNT_W-1:0] limit;
    int                 phase;
    src_pool[0] = '0;
    src_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) src_pool[i] = $urandom();
    lo_addr = src_pool[0];
    hi_addr = src_pool[1];

    queue_op(OP_CHECK, lo_addr, 1'b0);
    queue_op(OP_REMOVE, lo_addr, 1'b0);
    queue_op(OP_CHKUPD, lo_addr, 1'b0);
    queue_op(OP_SETUPD, lo_addr, 1'b1);   // absent address is accepted
    queue_op(OP_INSERT, lo_addr, 1'b0);
    queue_op(OP_INSERT, hi_addr, 1'b1);
    queue_op(OP_SETUPD, lo_addr, 1'b1);   // single connection never locks
    queue_op(OP_CHKUPD, lo_addr, 1'b0);
    queue_op(OP_INSERT, lo_addr, 1'b0);
    queue_op(OP_CHKUPD, lo_addr, 1'b0);   // now pending
    queue_op(OP_SETUPD, lo_addr, 1'b0);   // refused while pending
    queue_op(OP_SPARE5, lo_addr, 1'b1);
    queue_op(OP_SPARE6, hi_addr, 1'b1);
    queue_op(OP_SPARE7, 32'h1234_5678, 1'b0);
    queue_op(OP_REMOVE, lo_addr, 1'b1);
    queue_op(OP_SETUPD, lo_addr, 1'b0);
    queue_op(OP_REMOVE, lo_addr, 1'b0);   // slot freed
    queue_op(OP_CHECK, lo_addr, 1'b0);
    queue_limit(16'd1);
    queue_op(OP_CHECK, hi_addr, 1'b0);    // count at the limit
    queue_op(OP_CHECK, lo_addr, 1'b0);
    queue_limit('0);
    queue_op(OP_CHECK, lo_addr, 1'b0);    // zero limit blocks new addresses
    queue_op(OP_CHECK, hi_addr, 1'b0);
    queue_op(OP_INSERT, lo_addr, 1'b0);
    queue_op(OP_REMOVE, lo_addr, 1'b0);
    queue_op(OP_REMOVE, hi_addr, 1'b0);

    phase = 0;
    while (n_items < ITEM_GOAL) begin
      case (phase)
        0:       limit = '1;
        1:       limit = 16'd2;
        2:       limit = '0;
        3:       limit = 16'd3;
        default: begin
          case ($urandom_range(3))
            0:       limit = 16'd1;
            1:       limit = 16'd4;
            2:       limit = 16'($urandom_range(65535));
            default: limit = '1;
          endcase
        end
      endcase
      queue_limit(limit);
      gap_pct = 25 * $urandom_range(2);
      if (phase == 1 || (phase > 3 && $urandom_range(4) == 0)) begin
        queue_fill_sweep();
      end else begin
        case ($urandom_range(3))
          0:       queue_mix(2, 100);
          1:       queue_mix(4, 100);
          2:       queue_mix(8, 100);
          default: queue_mix(24, 100);
        endcase
      end
      phase++;
    end

    do @(posedge clk); while (conn_events.size() != 0 || in_flight != 0 || start);
    repeat (DRAIN_CYC) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk) begin : driver
    logic took;
    logic next_start;
    logic next_cfg;
    took       = 1'b0;
    next_start = 1'b0;
    next_cfg   = 1'b0;
    if (!rst_n) begin
      in_flight    = 0;
      gap_left     = -1;
      shadow_limit = MAX_PER_RST;
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    end else begin
      took = start && busy === 1'b0;
      if (took) begin
        pending_outcomes.push_back(predict_table_op(in_opcode, in_address, in_update_value));
        in_flight++;
      end
      if (out_valid === 1'b1) in_flight--;
      if (start && !took) begin
        next_start = 1'b1;
      end else if (conn_events.size() != 0) begin
        if (conn_events[0].is_limit) begin
          // limit changes only with the block idle and every result in
          if (in_flight == 0 && busy === 1'b0 && !cfg_wr_en) begin
            next_cfg     = 1'b1;
            cfg_wr_data  <= conn_events[0].limit;
            shadow_limit = conn_events[0].limit;
            void'(conn_events.pop_front());
          end
        end else begin
          if (gap_left < 0) gap_left = conn_events[0].gap;
          // idle cycles only count once the block could take the transfer
          if (gap_left > 0) begin
            if (busy === 1'b0) gap_left--;
          end else begin
            next_start      = 1'b1;
            in_opcode       <= conn_events[0].op;
            in_address      <= conn_events[0].addr;
            in_update_value <= conn_events[0].upd;
            void'(conn_events.pop_front());
            gap_left = -1;
          end
        end
      end
    end
    start     <= next_start;
    cfg_wr_en <= next_cfg;
  end

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst_n && out_valid === 1'b1) begin
      got.answer = out_answer;
      got.found  = out_found;
      got.full   = out_table_full;
      got.count  = out_count_after;
      if (pending_outcomes.size() == 0) begin
        flag_mismatch($sformatf("unexpected result answer=%0b found=%0b full=%0b count=%0d",
                                got.answer, got.found, got.full, got.count));
      end else begin
        want = pending_outcomes.pop_front();
        if (got.answer !== want.answer || got.found !== want.found ||
            got.full !== want.full || got.count !== want.count) begin
          flag_mismatch($sformatf({"wrong result: expected answer=%0b found=%0b full=%0b ",
                                   "count=%0d, got answer=%0b found=%0b full=%0b count=%0d"},
                                  want.answer, want.found, want.full, want.count,
                                  got.answer, got.found, got.full, got.count));
        end
      end
    end
  end

  // counts cycles without any transfer, result or register write
  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1 || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
